[hdl/tmt_pkg.sv]
// ----------------------------------------------------------------------------
// tmt_pkg
// Shared types, constants and midpoint helpers of the triangle tessellator.
// ----------------------------------------------------------------------------
`default_nettype none

package tmt_pkg;

  localparam int MAX_LEVELS = 4;
  localparam int COORD_W    = 16;
  localparam int LEVEL_W    = 3;
  localparam int DEPTH_W    = (MAX_LEVELS > 1) ? $clog2(MAX_LEVELS) : 1;
  localparam int Q_DEPTH    = 2;
  localparam int Q_AW       = $clog2(Q_DEPTH);
  localparam int Q_CW       = $clog2(Q_DEPTH + 1);

  localparam logic [1:0] LAST_CHILD = 2'd3;

  typedef logic signed [COORD_W-1:0] coord_t;

  typedef struct packed {
    coord_t x;
    coord_t y;
    coord_t z;
  } vtx_t;

  typedef struct packed {
    vtx_t v2;
    vtx_t v1;
    vtx_t v0;
  } tri_t;

  typedef struct packed {
    coord_t              v0_x;
    coord_t              v0_y;
    coord_t              v0_z;
    coord_t              v1_x;
    coord_t              v1_y;
    coord_t              v1_z;
    coord_t              v2_x;
    coord_t              v2_y;
    coord_t              v2_z;
    logic [LEVEL_W-1:0]  level;
  } in_beat_t;

  typedef struct packed {
    coord_t out0_x;
    coord_t out0_y;
    coord_t out0_z;
    coord_t out1_x;
    coord_t out1_y;
    coord_t out1_z;
    coord_t out2_x;
    coord_t out2_y;
    coord_t out2_z;
    logic   last;
  } out_beat_t;

  // one queued job: source triangle and depth at which leaves are emitted
  typedef struct packed {
    tri_t               src;
    logic [DEPTH_W-1:0] leaf;
  } job_t;

  typedef struct packed {
    logic valid;
    logic full;
  } q_stat_t;

  // (a+b)/2 truncating toward zero
  function automatic coord_t half_sum(input coord_t a, input coord_t b);
    logic signed [COORD_W:0] sum;
    logic signed [COORD_W:0] adj;
    sum = {a[COORD_W-1], a} + {b[COORD_W-1], b};
    adj = sum + {{COORD_W{1'b0}}, sum[COORD_W] & sum[0]};
    return adj[COORD_W:1];
  endfunction

  function automatic vtx_t mid(input vtx_t a, input vtx_t b);
    vtx_t m;
    m.x = half_sum(a.x, b.x);
    m.y = half_sum(a.y, b.y);
    m.z = half_sum(a.z, b.z);
    return m;
  endfunction

  function automatic tri_t child(input tri_t t, input logic [1:0] pos);
    vtx_t m01;
    vtx_t m02;
    vtx_t m12;
    tri_t c;
    m01 = mid(t.v0, t.v1);
    m02 = mid(t.v0, t.v2);
    m12 = mid(t.v1, t.v2);
    unique case (pos)
      2'd0: begin c.v0 = t.v0; c.v1 = m01;  c.v2 = m02;  end
      2'd1: begin c.v0 = m12;  c.v1 = m02;  c.v2 = m01;  end
      2'd2: begin c.v0 = m02;  c.v1 = m12;  c.v2 = t.v2; end
      default: begin c.v0 = m01; c.v1 = t.v1; c.v2 = m12; end
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

[hdl/tmt_channels.sv]
// ----------------------------------------------------------------------------
// tmt_channels
// Valid/ready channel interfaces for triangle input and output beats.
// ----------------------------------------------------------------------------
`default_nettype none

interface tmt_in_if;
  logic               valid;
  logic               ready;
  tmt_pkg::in_beat_t  data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface tmt_out_if;
  logic               valid;
  logic               ready;
  tmt_pkg::out_beat_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

[hdl/tmt_front.sv]
// ----------------------------------------------------------------------------
// tmt_front
// Accepts input beats, drops level zero, clamps the level, builds a job.
// ----------------------------------------------------------------------------
`default_nettype none

module tmt_front (
  tmt_in_if.sink          in_ch,
  input  tmt_pkg::q_stat_t q_stat,
  output logic            push,
  output tmt_pkg::job_t   job
);

  logic [tmt_pkg::LEVEL_W-1:0] lvl_sat;

  assign in_ch.ready = !q_stat.full;

  always_comb begin
    if (in_ch.data.level > tmt_pkg::LEVEL_W'(tmt_pkg::MAX_LEVELS)) begin
      lvl_sat = tmt_pkg::LEVEL_W'(tmt_pkg::MAX_LEVELS);
    end else begin
      lvl_sat = in_ch.data.level;
    end
  end

  // level zero is consumed but yields nothing
  assign push = in_ch.valid && in_ch.ready && (in_ch.data.level != '0);

  always_comb begin
    job.src.v0.x = in_ch.data.v0_x;
    job.src.v0.y = in_ch.data.v0_y;
    job.src.v0.z = in_ch.data.v0_z;
    job.src.v1.x = in_ch.data.v1_x;
    job.src.v1.y = in_ch.data.v1_y;
    job.src.v1.z = in_ch.data.v1_z;
    job.src.v2.x = in_ch.data.v2_x;
    job.src.v2.y = in_ch.data.v2_y;
    job.src.v2.z = in_ch.data.v2_z;
    job.leaf     = tmt_pkg::DEPTH_W'(lvl_sat - 1'b1);
  end

endmodule

`default_nettype wire

[hdl/tmt_queue.sv]
// ----------------------------------------------------------------------------
// tmt_queue
// Small job queue between front and back.
// ----------------------------------------------------------------------------
`default_nettype none

module tmt_queue (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  tmt_pkg::job_t    wr_job,
  input  logic             pop,
  output tmt_pkg::job_t    rd_job,
  output tmt_pkg::q_stat_t q_stat
);

  tmt_pkg::job_t              mem_r [tmt_pkg::Q_DEPTH];
  logic [tmt_pkg::Q_AW-1:0]   wr_ptr_r;
  logic [tmt_pkg::Q_AW-1:0]   wr_ptr_nxt;
  logic [tmt_pkg::Q_AW-1:0]   rd_ptr_r;
  logic [tmt_pkg::Q_AW-1:0]   rd_ptr_nxt;
  logic [tmt_pkg::Q_CW-1:0]   cnt_r;
  logic [tmt_pkg::Q_CW-1:0]   cnt_nxt;

  assign q_stat.valid = (cnt_r != '0);
  assign q_stat.full  = (cnt_r == tmt_pkg::Q_CW'(tmt_pkg::Q_DEPTH));
  assign rd_job       = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == tmt_pkg::Q_AW'(tmt_pkg::Q_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == tmt_pkg::Q_AW'(tmt_pkg::Q_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    unique case ({push, pop})
      2'b10:   cnt_nxt = cnt_r + 1'b1;
      2'b01:   cnt_nxt = cnt_r - 1'b1;
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wr_job;
    end
  end

endmodule

`default_nettype wire

[hdl/tmt_back.sv]
// ----------------------------------------------------------------------------
// tmt_back
// Depth-first subdivision sequencer with a per-depth triangle stack.
// ----------------------------------------------------------------------------
`default_nettype none

module tmt_back (
  input  logic             clk,
  input  logic             rst_n,
  input  tmt_pkg::q_stat_t q_stat,
  input  tmt_pkg::job_t    rd_job,
  output logic             pop,
  tmt_out_if.source        out_ch
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_RUN  = 3'b010,
    S_UP   = 3'b100
  } state_t;

  state_t                          state_r;
  state_t                          state_nxt;
  logic [tmt_pkg::DEPTH_W-1:0]     dep_r;
  logic [tmt_pkg::DEPTH_W-1:0]     dep_nxt;
  logic [tmt_pkg::DEPTH_W-1:0]     leaf_r;
  logic [tmt_pkg::DEPTH_W-1:0]     leaf_nxt;
  logic [1:0]          cp_r   [tmt_pkg::MAX_LEVELS];
  logic [1:0]          cp_nxt [tmt_pkg::MAX_LEVELS];
  tmt_pkg::tri_t       tri_r  [tmt_pkg::MAX_LEVELS];
  tmt_pkg::out_beat_t  out_r;
  tmt_pkg::out_beat_t  out_nxt;
  logic                out_vld_r;
  logic                out_vld_nxt;

  logic                            tri_we;
  logic [tmt_pkg::DEPTH_W-1:0]     tri_wa;
  tmt_pkg::tri_t       tri_wd;
  tmt_pkg::tri_t       cur;
  tmt_pkg::tri_t       kid;
  logic                out_free;
  logic                all_last;
  logic                deeper;
  logic                emit;
  tmt_pkg::tri_t       emit_tri;
  logic                emit_last;

  assign cur      = tri_r[dep_r];
  assign kid      = tmt_pkg::child(cur, cp_r[dep_r]);
  assign out_free = !out_vld_r || out_ch.ready;
  assign deeper   = ({1'b0, dep_r} + 1'b1) < {1'b0, leaf_r};

  // last leaf when every open level sits on its final child
  always_comb begin
    all_last = 1'b1;
    for (int i = 0; i < tmt_pkg::MAX_LEVELS; i++) begin
      if (tmt_pkg::DEPTH_W'(i) <= dep_r && cp_r[i] != tmt_pkg::LAST_CHILD) begin
        all_last = 1'b0;
      end
    end
  end

  always_comb begin
    state_nxt = state_r;
    dep_nxt   = dep_r;
    leaf_nxt  = leaf_r;
    cp_nxt    = cp_r;
    pop       = 1'b0;
    tri_we    = 1'b0;
    tri_wa    = '0;
    tri_wd    = rd_job.src;
    emit      = 1'b0;
    emit_tri  = kid;
    emit_last = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (q_stat.valid) begin
          pop       = 1'b1;
          tri_we    = 1'b1;
          leaf_nxt  = rd_job.leaf;
          dep_nxt   = '0;
          for (int i = 0; i < tmt_pkg::MAX_LEVELS; i++) begin
            cp_nxt[i] = '0;
          end
          state_nxt = S_RUN;
        end
      end
      S_RUN: begin
        if (leaf_r == '0) begin
          if (out_free) begin
            emit      = 1'b1;
            emit_tri  = cur;
            emit_last = 1'b1;
            state_nxt = S_IDLE;
          end
        end else if (deeper) begin
          // descend into the current child
          tri_we              = 1'b1;
          tri_wa              = dep_r + 1'b1;
          tri_wd              = kid;
          cp_nxt[dep_r + 1'b1] = '0;
          dep_nxt             = dep_r + 1'b1;
        end else if (out_free) begin
          emit      = 1'b1;
          emit_last = all_last;
          if (cp_r[dep_r] != tmt_pkg::LAST_CHILD) begin
            cp_nxt[dep_r] = cp_r[dep_r] + 1'b1;
          end else if (all_last) begin
            state_nxt = S_IDLE;
          end else begin
            dep_nxt   = dep_r - 1'b1;
            state_nxt = S_UP;
          end
        end
      end
      S_UP: begin
        if (cp_r[dep_r] == tmt_pkg::LAST_CHILD) begin
          dep_nxt = dep_r - 1'b1;
        end else begin
          cp_nxt[dep_r] = cp_r[dep_r] + 1'b1;
          state_nxt     = S_RUN;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    out_nxt     = out_r;
    out_vld_nxt = out_vld_r && !out_ch.ready;
    if (emit) begin
      out_vld_nxt    = 1'b1;
      out_nxt.out0_x = emit_tri.v0.x;
      out_nxt.out0_y = emit_tri.v0.y;
      out_nxt.out0_z = emit_tri.v0.z;
      out_nxt.out1_x = emit_tri.v1.x;
      out_nxt.out1_y = emit_tri.v1.y;
      out_nxt.out1_z = emit_tri.v1.z;
      out_nxt.out2_x = emit_tri.v2.x;
      out_nxt.out2_y = emit_tri.v2.y;
      out_nxt.out2_z = emit_tri.v2.z;
      out_nxt.last   = emit_last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      dep_r     <= '0;
      leaf_r    <= '0;
      out_vld_r <= 1'b0;
      for (int i = 0; i < tmt_pkg::MAX_LEVELS; i++) begin
        cp_r[i] <= '0;
      end
    end else begin
      state_r   <= state_nxt;
      dep_r     <= dep_nxt;
      leaf_r    <= leaf_nxt;
      out_vld_r <= out_vld_nxt;
      cp_r      <= cp_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r <= out_nxt;
    if (tri_we) begin
      tri_r[tri_wa] <= tri_wd;
    end
  end

  assign out_ch.valid = out_vld_r;
  assign out_ch.data  = out_r;

endmodule

`default_nettype wire

[hdl/triangle_midpoint_tessellator_core.sv]
// ----------------------------------------------------------------------------
// triangle_midpoint_tessellator_core
// Midpoint subdivision of one triangle into 4^(level-1) triangles.
// ----------------------------------------------------------------------------
// Each input beat carries a triangle and a level from 1 to 4 (higher levels
// clamp to 4, level 0 is consumed and emits nothing). The front side queues
// up to two jobs; the back side walks the subdivision depth first and, while
// the output is not stalled, emits one triangle per cycle within each group
// of four siblings; descents and steps back up the stack emit nothing.
// The final triangle of each job has last set.
// ----------------------------------------------------------------------------
`default_nettype none

module triangle_midpoint_tessellator_core (
  input  logic       clk,
  input  logic       rst_n,
  tmt_in_if.sink     in_ch,
  tmt_out_if.source  out_ch
);

  logic              push;
  logic              pop;
  tmt_pkg::job_t     wr_job;
  tmt_pkg::job_t     rd_job;
  tmt_pkg::q_stat_t  q_stat;

  tmt_front u_front (
    .in_ch  (in_ch),
    .q_stat (q_stat),
    .push   (push),
    .job    (wr_job)
  );

  tmt_queue u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (push),
    .wr_job (wr_job),
    .pop    (pop),
    .rd_job (rd_job),
    .q_stat (q_stat)
  );

  tmt_back u_back (
    .clk    (clk),
    .rst_n  (rst_n),
    .q_stat (q_stat),
    .rd_job (rd_job),
    .pop    (pop),
    .out_ch (out_ch)
  );

  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !q_stat.full)
    else $error("job pushed into a full queue");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> q_stat.valid)
    else $error("job popped from an empty queue");

  a_level0_drop: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready && in_ch.data.level == '0) |-> !push)
    else $error("level zero beat produced a job");

  a_level_push: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready && in_ch.data.level != '0) |-> push)
    else $error("accepted beat lost before the queue");

endmodule

`default_nettype wire
